[rtl/mrsv_pkg.sv]
// Shared types and constants for the mesh region signed volume unit.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mrsv_pkg;

	localparam int REGIONS = 16;
	localparam int REGION_W = 4;
	localparam int REG_AW = $clog2(REGIONS);
	localparam int COORD_W = 16;
	localparam int COORD_BITS = 16;
	localparam int VOL_W = 64;
	localparam int TERM_W = 56;
	localparam int RC_W = 5;
	localparam int DUMP_MAX = (REGIONS < 16) ? REGIONS : 16;
	localparam int DUMP_W = $clog2(DUMP_MAX);
	localparam int QDEPTH = 8;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int OCC_W = $clog2(QDEPTH + 1);
	localparam int CFG_INDEX_W = 2;

	localparam logic [RC_W-1:0] RC_RESET = RC_W'(16);
	localparam logic signed [VOL_W-1:0] VOL_MAX = {1'b0, {(VOL_W-1){1'b1}}};
	localparam logic signed [VOL_W-1:0] VOL_MIN = {1'b1, {(VOL_W-1){1'b0}}};

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_REGION_COUNT   = 2'd0,
		CFG_OUTSIDE_REGION = 2'd1,
		CFG_DOMAIN_VOLUME  = 2'd2
	} cfg_index_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] az;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] bz;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
		logic [REGION_W-1:0] negative_region;
		logic [REGION_W-1:0] positive_region;
		logic last_triangle;
	} triangle_t;

	typedef struct packed {
		logic [REGION_W-1:0] region_index;
		logic signed [VOL_W-1:0] region_volume;
		logic last_region;
	} result_t;

	typedef struct packed {
		logic [REGION_W-1:0] neg_region;
		logic [REGION_W-1:0] pos_region;
		logic last;
	} item_meta_t;

	typedef struct packed {
		logic signed [TERM_W-1:0] term;
		item_meta_t meta;
	} work_item_t;

	typedef struct packed {
		logic [RC_W-1:0] region_count;
		logic [REGION_W-1:0] outside_region;
		logic signed [VOL_W-1:0] domain_volume;
	} back_cfg_t;

	// Take the low COORD_BITS bits as a two's complement value.
	function automatic logic signed [COORD_W-1:0] coord_sext(input logic [COORD_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		r = $signed(v << (COORD_W - COORD_BITS));
		return r >>> (COORD_W - COORD_BITS);
	endfunction

endpackage

`default_nettype wire

[rtl/mesh_region_signed_volume_unit.sv]
// Mesh region signed volume unit: top level with configuration registers and item credit.
// A triangle's term reaches the table through the front-end pipeline and the queue; after the last
// triangle the dump sends out the region totals, one total per cycle.
// Each triangle takes two table accesses in turn (negative side, then positive side).
// busy rises while 8 triangles are in flight; a dump holds the table until its last region total is read.
// Reset: control and registers go to their reset values; the table is not cleared, valid bits do it.
`default_nettype none

module mesh_region_signed_volume_unit import mrsv_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire triangle_t               triangle,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [VOL_W-1:0]        cfg_data,
	output logic                         strobe,
	output result_t                      result
);

	logic accept;
	logic push, pop, q_valid;
	work_item_t front_item, q_head;
	back_cfg_t cfg_q;
	logic [OCC_W-1:0] occ_q;

	// Hold a credit for every item between accept and pop; the queue can then never overflow.
	assign busy = (occ_q == OCC_W'(QDEPTH));
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OCC_W'(accept) - OCC_W'(pop);
		end
	end

	// Configuration registers; writes to an unknown index drop silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region_count <= RC_RESET;
			cfg_q.outside_region <= '0;
			cfg_q.domain_volume <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REGION_COUNT: begin
					cfg_q.region_count <= cfg_data[RC_W-1:0];
				end
				CFG_OUTSIDE_REGION: begin
					cfg_q.outside_region <= cfg_data[REGION_W-1:0];
				end
				CFG_DOMAIN_VOLUME: begin
					cfg_q.domain_volume <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Front end: term pipeline.
	mrsv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.triangle (triangle),
		.push     (push),
		.item     (front_item)
	);

	// Decouple the pipeline from the table sequencer.
	mrsv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.pop       (pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	// Back end: region table updates and the dump at batch end.
	mrsv_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_head),
		.pop     (pop),
		.cfg     (cfg_q),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

`default_nettype wire

[rtl/mrsv_front.sv]
// Front end: accepts triangles and forms the divergence term in a 5-stage pipeline.
// Depends on mrsv_pkg.
`default_nettype none

module mrsv_front import mrsv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	input  wire triangle_t  triangle,
	output logic            push,
	output work_item_t      item
);

	logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	item_meta_t meta_s1, meta_s2, meta_s3, meta_s4;

	logic signed [COORD_W:0] ux_s1, uy_s1, uz_s1, vx_s1, vy_s1, vz_s1;
	logic signed [COORD_W+1:0] sx_s1, sy_s1, sz_s1;
	logic signed [COORD_W+1:0] sx_s2, sy_s2, sz_s2;
	logic signed [COORD_W+1:0] sx_s3, sy_s3, sz_s3;
	logic signed [2*COORD_W+1:0] p_yz_s2, p_zy_s2, p_zx_s2, p_xz_s2, p_xy_s2, p_yx_s2;
	logic signed [2*COORD_W+2:0] nx_s3, ny_s3, nz_s3;
	logic signed [3*COORD_W+4:0] tx_s4, ty_s4, tz_s4;
	work_item_t item_s5;

	assign ax = coord_sext(triangle.ax);
	assign ay = coord_sext(triangle.ay);
	assign az = coord_sext(triangle.az);
	assign bx = coord_sext(triangle.bx);
	assign by = coord_sext(triangle.by);
	assign bz = coord_sext(triangle.bz);
	assign cx = coord_sext(triangle.cx);
	assign cy = coord_sext(triangle.cy);
	assign cz = coord_sext(triangle.cz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		// edge vectors and vertex sums
		ux_s1 <= (COORD_W+1)'(bx) - (COORD_W+1)'(ax);
		uy_s1 <= (COORD_W+1)'(by) - (COORD_W+1)'(ay);
		uz_s1 <= (COORD_W+1)'(bz) - (COORD_W+1)'(az);
		vx_s1 <= (COORD_W+1)'(cx) - (COORD_W+1)'(ax);
		vy_s1 <= (COORD_W+1)'(cy) - (COORD_W+1)'(ay);
		vz_s1 <= (COORD_W+1)'(cz) - (COORD_W+1)'(az);
		sx_s1 <= (COORD_W+2)'(ax) + (COORD_W+2)'(bx) + (COORD_W+2)'(cx);
		sy_s1 <= (COORD_W+2)'(ay) + (COORD_W+2)'(by) + (COORD_W+2)'(cy);
		sz_s1 <= (COORD_W+2)'(az) + (COORD_W+2)'(bz) + (COORD_W+2)'(cz);
		meta_s1 <= '{neg_region: triangle.negative_region,
			pos_region: triangle.positive_region, last: triangle.last_triangle};

		// cross product partial products
		p_yz_s2 <= (2*COORD_W+2)'(uy_s1) * (2*COORD_W+2)'(vz_s1);
		p_zy_s2 <= (2*COORD_W+2)'(uz_s1) * (2*COORD_W+2)'(vy_s1);
		p_zx_s2 <= (2*COORD_W+2)'(uz_s1) * (2*COORD_W+2)'(vx_s1);
		p_xz_s2 <= (2*COORD_W+2)'(ux_s1) * (2*COORD_W+2)'(vz_s1);
		p_xy_s2 <= (2*COORD_W+2)'(ux_s1) * (2*COORD_W+2)'(vy_s1);
		p_yx_s2 <= (2*COORD_W+2)'(uy_s1) * (2*COORD_W+2)'(vx_s1);
		sx_s2 <= sx_s1;
		sy_s2 <= sy_s1;
		sz_s2 <= sz_s1;
		meta_s2 <= meta_s1;

		// normal
		nx_s3 <= (2*COORD_W+3)'(p_yz_s2) - (2*COORD_W+3)'(p_zy_s2);
		ny_s3 <= (2*COORD_W+3)'(p_zx_s2) - (2*COORD_W+3)'(p_xz_s2);
		nz_s3 <= (2*COORD_W+3)'(p_xy_s2) - (2*COORD_W+3)'(p_yx_s2);
		sx_s3 <= sx_s2;
		sy_s3 <= sy_s2;
		sz_s3 <= sz_s2;
		meta_s3 <= meta_s2;

		// dot product terms
		tx_s4 <= (3*COORD_W+5)'(sx_s3) * (3*COORD_W+5)'(nx_s3);
		ty_s4 <= (3*COORD_W+5)'(sy_s3) * (3*COORD_W+5)'(ny_s3);
		tz_s4 <= (3*COORD_W+5)'(sz_s3) * (3*COORD_W+5)'(nz_s3);
		meta_s4 <= meta_s3;

		item_s5.term <= TERM_W'(tx_s4) + TERM_W'(ty_s4) + TERM_W'(tz_s4);
		item_s5.meta <= meta_s4;
	end

	assign push = v_s5;
	assign item = item_s5;

endmodule

`default_nettype wire

[rtl/mrsv_queue.sv]
// Short FIFO of finished terms between the front end and the table back end.
// Depends on mrsv_pkg.
`default_nettype none

module mrsv_queue import mrsv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire work_item_t  push_item,
	input  wire logic        pop,
	output logic             valid,
	output work_item_t       head
);

	work_item_t slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OCC_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + OCC_W'(push) - OCC_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	assign valid = (count_q != '0);
	assign head = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

[rtl/mrsv_back.sv]
// Back end: read-modify-write of the region table per item and the per-batch dump.
// Depends on mrsv_pkg.
`default_nettype none

module mrsv_back import mrsv_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire work_item_t  q_item,
	output logic             pop,
	input  wire back_cfg_t   cfg,
	output logic             strobe,
	output result_t          result
);

	typedef enum logic [3:0] {
		OP_NONE = 4'b0001,
		OP_NEG  = 4'b0010,
		OP_POS  = 4'b0100,
		OP_DUMP = 4'b1000
	} acc_op_t;

	typedef struct packed {
		logic signed [VOL_W-1:0] plus;
		logic signed [VOL_W-1:0] minus;
		item_meta_t meta;
	} cur_item_t;

	function automatic logic signed [VOL_W-1:0] sat_add(
		input logic signed [VOL_W-1:0] a,
		input logic signed [VOL_W-1:0] b
	);
		logic signed [VOL_W-1:0] s;
		s = a + b;
		if ((a[VOL_W-1] == b[VOL_W-1]) && (s[VOL_W-1] != a[VOL_W-1])) begin
			return a[VOL_W-1] ? VOL_MIN : VOL_MAX;
		end
		return s;
	endfunction

	function automatic logic in_range(input logic [REGION_W-1:0] r);
		return (int'(r) < REGIONS);
	endfunction

	logic signed [VOL_W-1:0] table_mem [REGIONS];
	logic [REGIONS-1:0] vld_q;

	cur_item_t cur_q;
	logic batch_open_q;
	logic [REGION_W-1:0] seed_idx_q;
	logic signed [VOL_W-1:0] seed_vol_q;

	logic dumping_q;
	logic [DUMP_W-1:0] dump_idx_q, dump_end_q, dump_end_w;

	acc_op_t op_s1;
	logic [REGION_W-1:0] region_s1;
	logic last_s1;
	logic signed [VOL_W-1:0] rd_data_s1;
	logic rd_vld_s1;
	logic fwd_hit_s1;
	logic signed [VOL_W-1:0] fwd_data_s1;

	acc_op_t issue_op;
	logic [REGION_W-1:0] issue_region;
	logic issue_last;
	logic dump_start;
	logic opening;

	logic signed [VOL_W-1:0] eff_data, operand, wr_data;
	logic wr_en;
	logic [REG_AW-1:0] wr_idx, rd_idx;

	logic strobe_q;
	result_t result_q;

	// dump length, clamped to one at least and the table size at most
	always_comb begin
		if (cfg.region_count == '0) begin
			dump_end_w = '0;
		end else if (int'(cfg.region_count) > DUMP_MAX) begin
			dump_end_w = DUMP_W'(DUMP_MAX - 1);
		end else begin
			dump_end_w = DUMP_W'(cfg.region_count - RC_W'(1));
		end
	end

	// pick the table access of this cycle
	always_comb begin
		issue_op = OP_NONE;
		issue_region = '0;
		issue_last = 1'b0;
		dump_start = 1'b0;
		pop = 1'b0;
		if (dumping_q) begin
			issue_op = OP_DUMP;
			issue_region = REGION_W'(dump_idx_q);
			issue_last = (dump_idx_q == dump_end_q);
		end else if (op_s1 == OP_NEG) begin
			issue_op = OP_POS;
			issue_region = cur_q.meta.pos_region;
		end else if (op_s1 == OP_POS && cur_q.meta.last) begin
			issue_op = OP_DUMP;
			issue_region = '0;
			issue_last = (dump_end_w == '0);
			dump_start = 1'b1;
		end else if (q_valid) begin
			issue_op = OP_NEG;
			issue_region = q_item.meta.neg_region;
			pop = 1'b1;
		end
	end

	assign opening = pop && !batch_open_q;
	assign rd_idx = issue_region[REG_AW-1:0];

	// entry not written in this batch reads as its seed
	always_comb begin
		if (fwd_hit_s1) begin
			eff_data = fwd_data_s1;
		end else if (rd_vld_s1) begin
			eff_data = rd_data_s1;
		end else if (region_s1 == seed_idx_q) begin
			eff_data = seed_vol_q;
		end else begin
			eff_data = '0;
		end
	end

	assign operand = (op_s1 == OP_NEG) ? cur_q.plus : cur_q.minus;
	assign wr_data = sat_add(eff_data, operand);
	assign wr_en = (op_s1 == OP_NEG || op_s1 == OP_POS) && in_range(region_s1);
	assign wr_idx = region_s1[REG_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
			dumping_q <= 1'b0;
			dump_idx_q <= '0;
			dump_end_q <= '0;
			batch_open_q <= 1'b0;
			vld_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			op_s1 <= issue_op;
			strobe_q <= (op_s1 == OP_DUMP);
			if (dump_start) begin
				dump_end_q <= dump_end_w;
				dump_idx_q <= DUMP_W'(1);
				dumping_q <= !issue_last;
			end else if (dumping_q) begin
				dump_idx_q <= dump_idx_q + DUMP_W'(1);
				if (issue_last) begin
					dumping_q <= 1'b0;
				end
			end
			if (issue_op == OP_DUMP && issue_last) begin
				batch_open_q <= 1'b0;
			end else if (opening) begin
				batch_open_q <= 1'b1;
			end
			if (opening) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_idx] <= wr_data;
		end
		rd_data_s1 <= table_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		region_s1 <= issue_region;
		last_s1 <= issue_last;
		rd_vld_s1 <= opening ? 1'b0 : vld_q[rd_idx];
		fwd_hit_s1 <= wr_en && (wr_idx == rd_idx);
		fwd_data_s1 <= wr_data;
		if (pop) begin
			cur_q.plus <= VOL_W'(q_item.term);
			cur_q.minus <= -VOL_W'(q_item.term);
			cur_q.meta <= q_item.meta;
		end
		if (opening) begin
			seed_idx_q <= cfg.outside_region;
			seed_vol_q <= cfg.domain_volume;
		end
		result_q.region_index <= region_s1;
		result_q.region_volume <= eff_data;
		result_q.last_region <= last_s1;
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_dump_follows_last: assert property (@(posedge clk) disable iff (!arst_n)
		(op_s1 == OP_POS && cur_q.meta.last) |=> (op_s1 == OP_DUMP))
		else $error("dump did not follow the last triangle");

	a_dump_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		dumping_q |-> (dump_idx_q <= dump_end_q))
		else $error("dump index ran past the dump length");

	a_open_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		opening |-> !wr_en)
		else $error("batch opened while a table write was in flight");

	a_no_pop_mid_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(dumping_q || op_s1 == OP_NEG) |-> !pop)
		else $error("item popped while the table was busy");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for mesh_region_signed_volume_unit: feeds triangle batches and checks
// every dumped region total against a cycle-free predictor of the region table.
// Depends on mrsv_pkg and the unit's top level only.
`default_nettype none

module tb_top import mrsv_pkg::*; ();

	// Index that decodes to no register; writes to it must leave every setting alone.
	localparam logic [CFG_INDEX_W-1:0] CFG_NO_REGISTER = 2'd3;
	localparam int COORD_MAX = 32767;
	localparam int COORD_MIN = -32768;

	// Predicts the region table and queues the totals each dump should produce.
	class region_volume_scoreboard;
		logic signed [VOL_W-1:0] sums [REGIONS];
		bit batch_open;
		logic [RC_W-1:0] region_count;
		logic [REGION_W-1:0] outside_region;
		logic signed [VOL_W-1:0] domain_volume;
		result_t totals_due [$];
		int errors;

		function void power_on();
			foreach (sums[i])
				sums[i] = '0;
			batch_open = 1'b0;
			region_count = RC_RESET;
			outside_region = '0;
			domain_volume = '0;
			totals_due.delete();
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [VOL_W-1:0] data);
			case (idx)
				CFG_REGION_COUNT: region_count = data[RC_W-1:0];
				CFG_OUTSIDE_REGION: outside_region = data[REGION_W-1:0];
				CFG_DOMAIN_VOLUME: domain_volume = data;
				default: ;
			endcase
		endfunction

		// 18 x signed volume term: dot(a+b+c, cross(b-a, c-a)); fits in 54 bits.
		function longint triangle_term(triangle_t t);
			longint ax, ay, az, bx, by, bz, cx, cy, cz;
			longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
			ax = $signed(t.ax); ay = $signed(t.ay); az = $signed(t.az);
			bx = $signed(t.bx); by = $signed(t.by); bz = $signed(t.bz);
			cx = $signed(t.cx); cy = $signed(t.cy); cz = $signed(t.cz);
			ux = bx - ax; uy = by - ay; uz = bz - az;
			vx = cx - ax; vy = cy - ay; vz = cz - az;
			nx = uy * vz - uz * vy;
			ny = uz * vx - ux * vz;
			nz = ux * vy - uy * vx;
			return (ax + bx + cx) * nx + (ay + by + cy) * ny + (az + bz + cz) * nz;
		endfunction

		function logic signed [VOL_W-1:0] sat_sum(logic signed [VOL_W-1:0] a, longint b);
			logic [VOL_W:0] s;
			s = {a[VOL_W-1], a} + {b[63], b};
			if (s[VOL_W] != s[VOL_W-1])
				return s[VOL_W] ? VOL_MIN : VOL_MAX;
			return s[VOL_W-1:0];
		endfunction

		function void note_triangle(triangle_t t);
			longint term;
			int n;
			result_t r;
			// Open the batch: clear the table, seed the outside region.
			if (!batch_open) begin
				foreach (sums[i])
					sums[i] = '0;
				if (int'(outside_region) < REGIONS)
					sums[outside_region] = domain_volume;
				batch_open = 1'b1;
			end
			term = triangle_term(t);
			// Negative side first, then positive side; both apply when they coincide.
			if (int'(t.negative_region) < REGIONS)
				sums[t.negative_region] = sat_sum(sums[t.negative_region], term);
			if (int'(t.positive_region) < REGIONS)
				sums[t.positive_region] = sat_sum(sums[t.positive_region], -term);
			if (!t.last_triangle)
				return;
			n = region_count;
			if (n < 1)
				n = 1;
			if (n > REGIONS)
				n = REGIONS;
			if (n > DUMP_MAX)
				n = DUMP_MAX;
			for (int k = 0; k < n; k++) begin
				r.region_index = REGION_W'(k);
				r.region_volume = sums[k];
				r.last_region = (k == n - 1);
				totals_due = {totals_due, r};
			end
			batch_open = 1'b0;
		endfunction

		function void check_total(result_t got);
			result_t want;
			if (totals_due.size() == 0) begin
				$error("region total with none expected: index %0d volume %0d",
					got.region_index, $signed(got.region_volume));
				errors++;
				return;
			end
			want = totals_due.pop_front();
			if (got.region_index !== want.region_index) begin
				$error("region_index: expected %0d, got %0d", want.region_index,
					got.region_index);
				errors++;
			end
			if (got.region_volume !== want.region_volume) begin
				$error("region_volume: expected %0d, got %0d", $signed(want.region_volume),
					$signed(got.region_volume));
				errors++;
			end
			if (got.last_region !== want.last_region) begin
				$error("last_region: expected %0d, got %0d", want.last_region,
					got.last_region);
				errors++;
			end
		endfunction

		function int pending();
			return totals_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	triangle_t triangle = '0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [VOL_W-1:0] cfg_data = '0;
	logic strobe;
	result_t result;

	region_volume_scoreboard sb;
	bit calm = 1'b0;	// set during the stretch where the sender never idles
	int sent;
	int blen;

	mesh_region_signed_volume_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.triangle(triangle),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.strobe(strobe),
		.result(result)
	);

	always #1 clk = ~clk;

	// Take every strobed total at the edge that ends its cycle; the bench cannot stall it.
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_total(result);
	end

	// Hold start and the triangle from a falling edge until the unit takes the item.
	// Entered and left just after a falling edge.
	task automatic drive_triangle(input triangle_t t);
		while (!calm && $urandom_range(99) < 11) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		triangle <= t;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_triangle(t);
		@(negedge clk);
	endtask

	// Drop start, let every queued total come out, then give the tail of the pipe time.
	task automatic settle();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	// One write, then the enable goes low again before the next write so it never toggles twice in one step.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [VOL_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic triangle_t shape(input int ax, ay, az, bx, by, bz, cx, cy, cz,
			input int neg, pos, input bit closes);
		triangle_t t;
		t.ax = COORD_W'(ax); t.ay = COORD_W'(ay); t.az = COORD_W'(az);
		t.bx = COORD_W'(bx); t.by = COORD_W'(by); t.bz = COORD_W'(bz);
		t.cx = COORD_W'(cx); t.cy = COORD_W'(cy); t.cz = COORD_W'(cz);
		t.negative_region = REGION_W'(neg);
		t.positive_region = REGION_W'(pos);
		t.last_triangle = closes;
		return t;
	endfunction

	// Mix corner values, small coordinates and full-range noise.
	function automatic int random_coord();
		int pick;
		pick = $urandom_range(9);
		case (pick)
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return int'($urandom_range(2)) - 1;
			3, 4: return int'($urandom_range(400)) - 200;
			default: return int'($signed(16'($urandom)));
		endcase
	endfunction

	function automatic triangle_t random_triangle(input bit closes);
		triangle_t t;
		t = shape(random_coord(), random_coord(), random_coord(),
			random_coord(), random_coord(), random_coord(),
			random_coord(), random_coord(), random_coord(),
			$urandom_range(15), $urandom_range(15), closes);
		// Put both sides in the same region now and then.
		if ($urandom_range(9) == 0)
			t.positive_region = t.negative_region;
		return t;
	endfunction

	task automatic random_reg_write();
		logic [VOL_W-1:0] data;
		int pick;
		data = {$urandom, $urandom};
		pick = $urandom_range(9);
		case ($urandom_range(3))
			0: begin
				// Upper bits stay noisy; only the low five count.
				if (pick == 0)
					data[RC_W-1:0] = '0;
				else if (pick == 1)
					data[RC_W-1:0] = 5'd1;
				else if (pick == 2)
					data[RC_W-1:0] = 5'd16;
				else if (pick == 3)
					data[RC_W-1:0] = 5'd31;
				write_reg(CFG_REGION_COUNT, data);
			end
			1: write_reg(CFG_OUTSIDE_REGION, data);
			2: begin
				if (pick < 2)
					data = VOL_MAX;
				else if (pick < 4)
					data = VOL_MIN;
				else if (pick == 4)
					data = '0;
				else if (pick == 5)
					data = '1;
				else if (pick == 6)
					data = VOL_MAX - VOL_W'($urandom);
				write_reg(CFG_DOMAIN_VOLUME, data);
			end
			default: write_reg(CFG_NO_REGISTER, data);
		endcase
	endtask

	initial begin
		sb = new;
		sb.power_on();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: full 16-region dump, outside region 0 seeded with zero.
		drive_triangle(shape(COORD_MAX, 0, 0, 0, COORD_MAX, 0, 0, 0, COORD_MAX, 1, 2, 1'b0));
		drive_triangle(shape(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
			COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, 15, 0, 1'b0));
		drive_triangle(shape(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
			COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 5, 5, 1'b0));
		drive_triangle(shape(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
			COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 7, 8, 1'b0));
		drive_triangle(shape(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
			COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 9, 9, 1'b0));
		drive_triangle(shape(COORD_MAX, 0, 0, 0, 0, COORD_MAX, 0, COORD_MAX, 0, 2, 1, 1'b1));
		settle();

		// Zero count clamps to a one-region dump; push region 0 past the top.
		write_reg(CFG_REGION_COUNT, '0);
		write_reg(CFG_OUTSIDE_REGION, 64'd0);
		write_reg(CFG_DOMAIN_VOLUME, VOL_MAX);
		drive_triangle(shape(COORD_MAX, 0, 0, 0, COORD_MAX, 0, 0, 0, COORD_MAX, 0, 15, 1'b0));
		drive_triangle(shape(COORD_MAX, 0, 0, 0, COORD_MAX, 0, 0, 0, COORD_MAX, 0, 15, 1'b0));
		drive_triangle(shape(COORD_MAX, 0, 0, 0, 0, COORD_MAX, 0, COORD_MAX, 0, 15, 0, 1'b1));
		settle();

		// Oversized count clamps to the full table; drive region 15 below the bottom,
		// with a same-side triangle whose order of updates matters at the floor.
		write_reg(CFG_REGION_COUNT, 64'd31);
		write_reg(CFG_NO_REGISTER, '1);
		write_reg(CFG_OUTSIDE_REGION, 64'd15);
		write_reg(CFG_DOMAIN_VOLUME, VOL_MIN);
		drive_triangle(shape(COORD_MAX, 0, 0, 0, COORD_MAX, 0, 0, 0, COORD_MAX, 9, 15, 1'b0));
		drive_triangle(shape(COORD_MAX, 0, 0, 0, 0, COORD_MAX, 0, COORD_MAX, 0, 15, 15, 1'b0));
		drive_triangle(random_triangle(1'b1));
		settle();

		// A batch of a single triangle with a one-region dump.
		write_reg(CFG_REGION_COUNT, 64'd1);
		write_reg(CFG_DOMAIN_VOLUME, '1);
		drive_triangle(shape(-3, 4, -5, 6, -7, 8, -9, 10, -11, 0, 0, 1'b1));

		// Random batches; settings change only between batches, after the pipe drains.
		sent = 0;
		while (sent < 155) begin
			blen = $urandom_range(1, 10);
			if ($urandom_range(1) == 1) begin
				settle();
				repeat ($urandom_range(1, 3)) random_reg_write();
			end
			for (int i = 0; i < blen; i++) begin
				calm = (sent >= 70 && sent < 130);
				drive_triangle(random_triangle(i == blen - 1));
				sent++;
			end
		end
		calm = 1'b0;

		start <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("** mesh_region_signed_volume_unit: PASSED **");
		end else begin
			$display("** mesh_region_signed_volume_unit: FAILED **");
		end
		$finish;
	end

	// Hard stop if the unit stalls or drops totals.
	initial begin
		#400000;
		$display("** mesh_region_signed_volume_unit: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

[sim.f]
rtl/mrsv_pkg.sv
rtl/mrsv_front.sv
rtl/mrsv_queue.sv
rtl/mrsv_back.sv
rtl/mesh_region_signed_volume_unit.sv
tb/tb_top.sv
